/* sv/wdq_pkg.sv */
// ---------------------------------------------------------------------------
// wdq_pkg - shared type and constant for the dequantising dot product
// Holds the queue entry type and the fp32 quiet NaN constant used by the back end.
// ---------------------------------------------------------------------------
package wdq_pkg;

  // Item queued between the accumulate front and the float back end
  typedef struct packed {
    logic [31:0] corr;
    logic [31:0] in_scale;
    logic [31:0] wt_scale;
  } wdq_job_t;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

endpackage

/* sv/wdq_if.sv */
// ---------------------------------------------------------------------------
// wdq_in_if / wdq_out_if - valid/ready channels
// Input items and result items of the dot product block.
// ---------------------------------------------------------------------------
interface wdq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] act_bytes;
  logic [31:0] weight_bytes;
  logic [2:0]  lanes_valid;
  logic        last;
  logic [7:0]  act_zp;
  logic signed [31:0] weight_row_sum;
  logic [31:0] act_scale;
  logic [31:0] weight_scale;
  modport source (output valid, act_bytes, weight_bytes, lanes_valid, last, act_zp,
                  weight_row_sum, act_scale, weight_scale, input ready);
  modport sink (input valid, act_bytes, weight_bytes, lanes_valid, last, act_zp,
                weight_row_sum, act_scale, weight_scale, output ready);
endinterface

interface wdq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic signed [31:0] corrected_sum;
  modport source (output valid, result_value, corrected_sum, input ready);
  modport sink (input valid, result_value, corrected_sum, output ready);
endinterface

/* sv/wdq_front.sv */
// ---------------------------------------------------------------------------
// wdq_front - accumulate front end
// Adds the lane products each transfer; on the last item applies the
// zero-point correction over two stages and hands a job to the queue.
// ---------------------------------------------------------------------------
module wdq_front
  import wdq_pkg::*;
#(
  parameter int LANES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_act,
  input  logic [31:0] in_wgt,
  input  logic [2:0]  in_lanes,
  input  logic        in_last,
  input  logic [7:0]  in_zp,
  input  logic [31:0] in_rsum,
  input  logic [31:0] in_iscale,
  input  logic [31:0] in_wscale,
  output logic        job_valid,
  input  logic        job_ready,
  output wdq_job_t    job
);

  localparam int FL = (LANES < 4) ? LANES : 4;

  logic [31:0] sum_r, sum_nxt;
  logic [31:0] lane_sum;
  // stage: product of zero point and row sum, with final sum
  logic        p_vld_r;
  logic [31:0] p_sum_r, p_zr_r, p_is_r, p_ws_r;
  logic        j_vld_r;
  wdq_job_t    j_r;
  logic        fire;

  assign in_ready = !p_vld_r && !(j_vld_r && !job_ready);
  assign fire     = in_valid && in_ready;

  // lane products of the valid lanes
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < FL; i++) begin
      if (3'(i) < in_lanes)
        lane_sum = lane_sum + 32'($signed({1'b0, in_act[8*i +: 8]}) *
                                  $signed(in_wgt[8*i +: 8]));
    end
    sum_nxt = sum_r + lane_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      p_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
    end else begin
      if (fire) sum_r <= in_last ? '0 : sum_nxt;
      p_vld_r <= fire && in_last;
      if (p_vld_r) j_vld_r <= 1'b1;
      else if (job_ready) j_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      p_sum_r <= sum_nxt;
      p_zr_r  <= 32'({24'd0, in_zp} * in_rsum);
      p_is_r  <= in_iscale;
      p_ws_r  <= in_wscale;
    end
    if (p_vld_r) begin
      j_r.corr     <= p_sum_r - p_zr_r;
      j_r.in_scale <= p_is_r;
      j_r.wt_scale <= p_ws_r;
    end
  end

  assign job_valid = j_vld_r;
  assign job       = j_r;

endmodule

/* sv/wdq_fmul.sv */
// ---------------------------------------------------------------------------
// wdq_fmul - fp32 multiply, round to nearest even, subnormals kept
// Combinational; the caller registers the product.
// ---------------------------------------------------------------------------
module wdq_fmul
  import wdq_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic        sg;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_z, b_z;
  logic [47:0] prod;
  logic [5:0]  lz;
  logic signed [10:0] e;
  logic [47:0] nrm;
  logic [49:0] sh;
  logic [23:0] man;
  logic        g, st, rup;
  logic [24:0] rnd;
  logic signed [10:0] ef;
  logic [7:0]  sa;

  always_comb begin
    sg = a[31] ^ b[31];
    ea = a[30:23]; eb = b[30:23];
    ma = {ea != 0, a[22:0]}; mb = {eb != 0, b[22:0]};
    a_nan = (ea == 8'hFF) && (a[22:0] != 0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 0);
    a_inf = (ea == 8'hFF) && (a[22:0] == 0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 0);
    a_z   = a[30:0] == 0; b_z = b[30:0] == 0;
    prod  = ma * mb;
    // leading one position
    lz = 6'd47;
    for (int i = 0; i < 48; i++)
      if (prod[i]) lz = 6'(47 - i);
    nrm = prod << lz;
    // value = nrm * 2^(e-127-... ), with leading one at bit 47
    e = 11'(ea == 0 ? 1 : ea) + 11'(eb == 0 ? 1 : eb) - 11'sd126 - 11'(lz);
    sh = {nrm, 2'b00};
    sa = 8'd0;
    if (e < 1) begin
      sa = (e < -30) ? 8'd31 : 8'(1 - e);
      sh = {nrm, 2'b00} >> sa;
    end
    // keep sticky of bits shifted out
    st  = |(sh[25:0]) || ((e < 1) && (|({nrm, 2'b00} & ~({50{1'b1}} << sa))));
    man = sh[49:26];
    g   = sh[25];
    st  = (|sh[24:0]) || ((e < 1) && (|({nrm, 2'b00} & ~({50{1'b1}} << sa))));
    rup = g && (st || man[0]);
    rnd = {1'b0, man} + 25'(rup);
    ef  = (e < 1) ? 11'sd0 : e;
    if (rnd[24]) begin
      rnd = rnd >> 1;
      ef  = ef + 11'sd1;
    end else if (ef == 0 && rnd[23]) begin
      ef = 11'sd1;
    end
    if (a_nan || b_nan || (a_inf && b_z) || (b_inf && a_z))
      p = QNAN;
    else if (a_inf || b_inf)
      p = {sg, 8'hFF, 23'd0};
    else if (a_z || b_z || prod == 0)
      p = {sg, 31'd0};
    else if (ef >= 11'sd255)
      p = {sg, 8'hFF, 23'd0};
    else
      p = {sg, ef[7:0], rnd[22:0]};
  end

endmodule

/* sv/wdq_back.sv */
// ---------------------------------------------------------------------------
// wdq_back - float back end
// Converts the corrected sum to fp32, then applies the two scales, one
// stage each, and holds the result in an output register.
// ---------------------------------------------------------------------------
module wdq_back
  import wdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  wdq_job_t    job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result,
  output logic [31:0] out_corr
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_CVT = 4'b0010, S_M1 = 4'b0100, S_OUT = 4'b1000
  } st_t;

  st_t st_r;
  wdq_job_t j_r;
  logic [31:0] f_r, m1_r;
  logic [31:0] cf, m1, m2;
  logic [31:0] mag;
  logic [4:0]  msb;
  logic [31:0] nrm;
  logic [24:0] r;
  logic [7:0]  ex;
  logic [31:0] res_r;
  logic        out_valid_q;

  assign job_ready = (st_r == S_IDLE);

  // int32 to fp32 with round to nearest even
  always_comb begin
    mag = j_r.corr[31] ? 32'(-j_r.corr) : j_r.corr;
    msb = '0;
    for (int i = 0; i < 32; i++)
      if (mag[i]) msb = 5'(i);
    nrm = mag << (5'd31 - msb);
    r   = {1'b0, nrm[31:8]} + 25'(nrm[7] && ((|nrm[6:0]) || nrm[8]));
    ex  = 8'd127 + 8'(msb) + 8'(r[24]);
    if (mag == 0) cf = 32'd0;
    else if (r[24]) cf = {j_r.corr[31], ex, 23'd0};
    else cf = {j_r.corr[31], ex, r[22:0]};
  end

  wdq_fmul u_m1 (.a(f_r),  .b(j_r.in_scale), .p(m1));
  wdq_fmul u_m2 (.a(m1_r), .b(j_r.wt_scale), .p(m2));

  // leave S_OUT only once the result transfer has happened
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else begin
      case (st_r)
        S_IDLE:  if (job_valid) st_r <= S_CVT;
        S_CVT:   st_r <= S_M1;
        S_M1:    st_r <= S_OUT;
        S_OUT:   if (out_valid_q && out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && job_valid) j_r <= job;
    if (st_r == S_CVT) f_r <= cf;
    if (st_r == S_M1) m1_r <= m1;
  end

  // second product registered into the output on the first S_OUT cycle
  always_ff @(posedge clk) begin
    if (st_r == S_OUT && !out_valid_q) res_r <= m2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_q <= 1'b0;
    else if (st_r == S_OUT && !out_valid_q) out_valid_q <= 1'b1;
    else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
  end

  assign out_valid  = out_valid_q;
  assign out_result = res_r;
  assign out_corr   = j_r.corr;

`ifndef ASSERT_OFF
  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_q |-> st_r == S_OUT) else $error("result without job");
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !job_ready) else $error("job taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_q && !out_ready |=> $stable(res_r)) else $error("result moved");
`endif

endmodule

/* sv/w8a8_dequant_dot_product.sv */
// ---------------------------------------------------------------------------
// w8a8_dequant_dot_product - u8 x s8 dot product with fp32 dequantisation
// Top level: accumulate front, job register, float back end.
// ---------------------------------------------------------------------------
// Each input transfer adds up to four lane products into a wrapping 32-bit
// sum, so a dot product streams at one item per cycle unless the input is
// held off. After the item marked last the input is held off while the
// zero-point product is formed; the corrected sum then sits in a single job
// register. The back end takes a job, converts it to fp32, applies the two
// scales in turn and presents the result; it takes no new job until the
// result of the last has been transferred. While the job register holds a
// job the back end has not yet taken, every input item waits.
module w8a8_dequant_dot_product
  import wdq_pkg::*;
#(
  parameter int LANES = 4
) (
  input logic clk,
  input logic rst_n,
  wdq_in_if.sink    in_ch,
  wdq_out_if.source out_ch
);

  logic     job_valid, job_ready;
  wdq_job_t job;
  logic [31:0] corr;

  wdq_front #(.LANES(LANES)) u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready(in_ch.ready),
    .in_act   (in_ch.act_bytes), .in_wgt(in_ch.weight_bytes),
    .in_lanes (in_ch.lanes_valid), .in_last(in_ch.last),
    .in_zp    (in_ch.act_zp), .in_rsum(in_ch.weight_row_sum),
    .in_iscale(in_ch.act_scale), .in_wscale(in_ch.weight_scale),
    .job_valid, .job_ready, .job
  );

  wdq_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .out_valid (out_ch.valid), .out_ready(out_ch.ready),
    .out_result(out_ch.result_value), .out_corr(corr)
  );

  assign out_ch.corrected_sum = corr;

endmodule
